FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the seven-segment digit reader. Each macro
// expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

FILE: rtl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment digit reader package
// Transaction types, segment masks, digit patterns and the divide-by-three
// helper shared by the reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

    localparam int SIDE_W = 10;

    localparam logic [7:0] PIXEL_LIT = 8'hFF;

    // Reciprocal of three for operands up to 11 bits: (x * 2731) >> 13.
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;
    localparam int          DIV3_PW    = 23;

    localparam logic [6:0] SEG_A = 7'h01;
    localparam logic [6:0] SEG_B = 7'h02;
    localparam logic [6:0] SEG_C = 7'h04;
    localparam logic [6:0] SEG_D = 7'h08;
    localparam logic [6:0] SEG_E = 7'h10;
    localparam logic [6:0] SEG_F = 7'h20;
    localparam logic [6:0] SEG_G = 7'h40;

    localparam int NUM_DIGITS = 10;

    localparam logic [6:0] DIGIT_PATTERN [NUM_DIGITS] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [7:0]        pixel;
        logic [SIDE_W-1:0] patch_rows;
        logic [SIDE_W-1:0] patch_cols;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       recognized;
        logic [6:0] segment_bits;
    } result_t;

    typedef struct packed {
        logic              lit;
        logic              last;
        logic [SIDE_W-1:0] patch_rows;
        logic [SIDE_W-1:0] patch_cols;
        logic [SIDE_W-1:0] col;
    } stage_t;

    function automatic logic [SIDE_W-1:0] div3(input logic [SIDE_W:0] x);
        logic [DIV3_PW-1:0] prod;
        prod = DIV3_PW'(x) * DIV3_PW'(DIV3_MUL);
        return prod[DIV3_SHIFT +: SIDE_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sdr_locate.sv
// ----------------------------------------------------------------------------
// Pixel locator
// Registers each pixel transaction together with its row and column within
// the patch and advances the position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_locate #(
    parameter int  MAX_SIDE = 1023,
    localparam int RowW     = $clog2(MAX_SIDE + 1)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pix_valid,
    output logic                 pix_stall,
    input  sdr_pkg::pixel_t      pix,
    input  wire logic            take,
    output logic                 s1_valid,
    output sdr_pkg::stage_t      s1,
    output logic [RowW-1:0]      s1_row
);

    logic                        accept;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    sdr_pkg::stage_t             s1_reg;
    logic [RowW-1:0]             s1_row_reg;
    logic [RowW-1:0]             row_reg;
    logic [RowW-1:0]             row_next;
    logic [sdr_pkg::SIDE_W-1:0]  col_reg;
    logic [sdr_pkg::SIDE_W-1:0]  col_next;
    logic [sdr_pkg::SIDE_W:0]    col_inc;

    assign pix_stall = s1_valid_reg && !take;
    assign accept    = pix_valid && !pix_stall;
    assign col_inc   = {1'b0, col_reg} + (sdr_pkg::SIDE_W + 1)'(1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (pix.last_pixel)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= {1'b0, pix.patch_cols})
            begin
                col_next = '0;
                if (row_reg < RowW'(MAX_SIDE))
                begin
                    row_next = row_reg + RowW'(1);
                end
            end
            else
            begin
                col_next = col_inc[sdr_pkg::SIDE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.lit        <= (pix.pixel == sdr_pkg::PIXEL_LIT);
            s1_reg.last       <= pix.last_pixel;
            s1_reg.patch_rows <= pix.patch_rows;
            s1_reg.patch_cols <= pix.patch_cols;
            s1_reg.col        <= col_reg;
            s1_row_reg        <= row_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;
    assign s1_row   = s1_row_reg;

`include "assert_macros.svh"

    `SDR_ASSERT_NEXT(a_pos_cleared_after_last, accept && pix.last_pixel,
                     row_reg == '0 && col_reg == '0)
    `SDR_ASSERT_SAME(a_no_overwrite, s1_valid_reg && !take, !accept)

endmodule

`default_nettype wire

FILE: rtl/sdr_accum.sv
// ----------------------------------------------------------------------------
// Segment accumulator and classifier
// Samples the seven segment positions from each located pixel, collects the
// segment flags over a patch and registers the recognized digit.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_accum #(
    parameter int  MAX_SIDE = 1023,
    localparam int RowW     = $clog2(MAX_SIDE + 1),
    localparam int CmpW     = (RowW > sdr_pkg::SIDE_W + 1) ? RowW : sdr_pkg::SIDE_W + 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s1_valid,
    input  sdr_pkg::stage_t      s1,
    input  wire logic [RowW-1:0] s1_row,
    output logic                 take,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output sdr_pkg::result_t     res
);

    logic [6:0]                  flags_reg;
    logic [6:0]                  flags_next;
    logic [6:0]                  seg_set;
    logic [6:0]                  flags_sum;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    sdr_pkg::result_t            res_reg;
    sdr_pkg::result_t            res_next;
    logic [CmpW-1:0]             row_x;
    logic [CmpW-1:0]             rows_x;
    logic [CmpW-1:0]             y1_x;
    logic [CmpW-1:0]             y2_x;
    logic [sdr_pkg::SIDE_W-1:0]  x_half;
    logic                        in_patch;
    logic                        left;
    logic [sdr_pkg::SIDE_W+1:0]  cols3;
    logic                        tall;
    logic                        hit;
    logic [3:0]                  match_digit;

    assign take = s1_valid && (!s1.last || !res_valid_reg || !res_stall);

    assign row_x  = CmpW'(s1_row);
    assign rows_x = CmpW'(s1.patch_rows);
    assign y1_x   = CmpW'(sdr_pkg::div3({1'b0, s1.patch_rows}));
    assign y2_x   = CmpW'(sdr_pkg::div3({s1.patch_rows, 1'b0}));
    assign x_half = s1.patch_cols >> 1;
    assign left   = s1.col < x_half;

    assign in_patch = s1.lit && (row_x < rows_x) && (s1.col < s1.patch_cols);

    always_comb
    begin
        seg_set = '0;
        if (in_patch)
        begin
            if (s1.col == x_half)
            begin
                if (row_x < y1_x)
                begin
                    seg_set = seg_set | sdr_pkg::SEG_A;
                end
                else if (row_x > y1_x && row_x < y2_x)
                begin
                    seg_set = seg_set | sdr_pkg::SEG_G;
                end
                else
                begin
                    seg_set = seg_set | sdr_pkg::SEG_D;
                end
            end
            if (row_x == y1_x)
            begin
                seg_set = seg_set | (left ? sdr_pkg::SEG_F : sdr_pkg::SEG_B);
            end
            if (row_x == y2_x)
            begin
                seg_set = seg_set | (left ? sdr_pkg::SEG_E : sdr_pkg::SEG_C);
            end
        end
    end

    assign flags_sum = flags_reg | seg_set;

    assign cols3 = {2'b00, s1.patch_cols} + {1'b0, s1.patch_cols, 1'b0};
    assign tall  = cols3 < {2'b00, s1.patch_rows};

    always_comb
    begin
        hit         = 1'b0;
        match_digit = '0;
        for (int k = sdr_pkg::NUM_DIGITS - 1; k >= 0; k--)
        begin
            if (flags_sum == sdr_pkg::DIGIT_PATTERN[k])
            begin
                hit         = 1'b1;
                match_digit = 4'(k);
            end
        end
    end

    always_comb
    begin
        res_next.segment_bits = flags_sum;
        if (tall)
        begin
            res_next.digit      = 4'd1;
            res_next.recognized = 1'b1;
        end
        else
        begin
            res_next.digit      = match_digit;
            res_next.recognized = hit;
        end
    end

    always_comb
    begin
        flags_next     = flags_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (take)
        begin
            if (s1.last)
            begin
                flags_next     = '0;
                res_valid_next = 1'b1;
            end
            else
            begin
                flags_next = flags_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg     <= flags_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s1.last)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`include "assert_macros.svh"

    `SDR_ASSERT_NEXT(a_result_after_last, take && s1.last,
                     res_valid_reg && flags_reg == '0)
    `SDR_ASSERT_SAME(a_plain_pixel_flows, s1_valid && !s1.last, take)
    `SDR_ASSERT_SAME(a_unrecognized_zero, res_valid_reg && !res_reg.recognized,
                     res_reg.digit == '0)

endmodule

`default_nettype wire

FILE: rtl/seven_segment_digit_reader.sv
// ----------------------------------------------------------------------------
// Seven-segment digit reader
// Reads one binary digit patch pixel by pixel and reports the digit.
//
// Input channel (pix_valid, pix_stall, pix): one pixel per transaction in
// row-major order, each carrying the patch height and width; last_pixel
// marks the end of the patch. Output channel (res_valid, res_stall, res):
// one result transaction per patch with the digit, a recognized flag and
// the sampled segment flags.
// Throughput is one pixel per cycle while pix_stall is low. A pixel passes an
// input register and is sampled into the segment flags in the following
// cycle; the result of a patch is registered in the output register after
// its last pixel has left the input register, and res_valid then rises.
// While a result waits under res_stall, ordinary pixels keep flowing; only
// the last pixel of the next patch is held in the input register, which
// then stalls the input channel until the waiting result is taken.
// Reset clears the position counters, the segment flags and both valids.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_digit_reader #(
    parameter int MAX_SIDE = 1023
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  sdr_pkg::pixel_t  pix,
    output logic             res_valid,
    input  wire logic        res_stall,
    output sdr_pkg::result_t res
);

    localparam int RowW = $clog2(MAX_SIDE + 1);

    logic            take;
    logic            s1_valid;
    sdr_pkg::stage_t s1;
    logic [RowW-1:0] s1_row;

    sdr_locate #(
        .MAX_SIDE (MAX_SIDE)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .take      (take),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .s1_row    (s1_row)
    );

    sdr_accum #(
        .MAX_SIDE (MAX_SIDE)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .s1_row    (s1_row),
        .take      (take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire
